/* hw/rtl/tcce_pkg.sv */
// shared constants, payload types, state encoding and address helpers of the text console
package tcce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 4;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = $clog2(COLUMNS + TAB_STEP);
    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]        ATTR_RESET = 8'h07;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        did_scroll;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] row_addr(
        input logic [ROW_W-1:0] prow,
        input logic [COL_W-1:0] col
    );
        return ADDR_W'(int'(prow) * COLUMNS + int'(col));
    endfunction

    // visible row to physical row through the ring offset, then to a cell address
    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W:0]   vrow,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W+1:0] sum;
        sum = {2'b00, top} + {1'b0, vrow};
        if (sum >= (ROW_W+2)'(ROWS))
        begin
            sum = sum - (ROW_W+2)'(ROWS);
        end
        return row_addr(sum[ROW_W-1:0], col);
    endfunction

endpackage

/* hw/rtl/tcce_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/text_console_cursor_engine_unit.sv */
// text console: cell store, cursor, scrolling and cell reads
//
// Requests come in on in_valid/in_ready/in_data. A put request handles one
// character byte at the cursor. A read request returns one visible cell. Every
// request gives exactly one result on out_valid/out_ready/out_data: the cell
// (0 for a put), the cursor after the request and a scroll flag.
// The attribute for new cells is written on cfg_valid/cfg_ready/cfg_data; the user is
// to write it only while the block is idle, which the block does not enforce. cfg_ready is always high.
// Cells live in one synchronous ram of ROWS*COLUMNS entries. Scrolling moves a
// ring offset and blanks the new bottom line, one cell per cycle.
// Timing: a put that does not scroll is taken as its result is registered, when
// the output register is free, so puts stream at one per cycle. A read goes through
// the ram read register, the pending result register and then the output register.
// A scrolling put first clears the new bottom line through the write port.
// After reset the ram is cleared to blank cells, one entry per cycle, over all
// ROWS*COLUMNS (2000) entries; in_ready stays low during that pass.
// When the receiver stalls, one finished result waits in the output register
// and the next request is still taken; its result then waits in the block,
// which takes no further request until the output register frees up.
module text_console_cursor_engine_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcce_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcce_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    tcce_pkg::state_t              state_reg, state_next;
    logic [7:0]                    attr_reg;
    logic [tcce_pkg::ROW_W-1:0]    top_reg, top_next;
    logic [tcce_pkg::ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [tcce_pkg::COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [tcce_pkg::ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [tcce_pkg::COL_W-1:0]    scr_cnt_reg, scr_cnt_next;
    logic [tcce_pkg::ROW_W-1:0]    scr_row_reg, scr_row_next;
    logic                          rd_hit_reg, rd_hit_next;
    tcce_pkg::out_item_t           pend_reg, pend_next;
    logic                          out_valid_reg, out_valid_next;
    tcce_pkg::out_item_t           out_reg, out_next;

    logic                          ram_wr_en;
    logic [tcce_pkg::ADDR_W-1:0]   ram_wr_addr;
    logic [tcce_pkg::CELL_W-1:0]   ram_wr_data;
    logic                          ram_rd_en;
    logic [tcce_pkg::ADDR_W-1:0]   ram_rd_addr;
    logic [tcce_pkg::CELL_W-1:0]   ram_rd_data;

    logic                          out_free;
    logic                          load_out;
    tcce_pkg::out_item_t           load_val;
    logic                          rd_in_range;

    // put path
    logic [tcce_pkg::ROW_W:0]      p_row;
    logic [tcce_pkg::COLX_W-1:0]   p_col;
    logic                          p_wr;
    logic [7:0]                    p_char;
    logic [tcce_pkg::ROW_W:0]      w_row;
    logic [tcce_pkg::COL_W-1:0]    w_col;
    logic                          p_scroll;
    logic [tcce_pkg::ROW_W-1:0]    p_row_final;
    tcce_pkg::out_item_t           p_res;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::DEPTH)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == tcce_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign rd_in_range = (in_data.read_row < tcce_pkg::ROWS)
                      && (in_data.read_col < tcce_pkg::COLUMNS);

    // cursor update and cell write of a put
    always_comb
    begin
        p_row  = {1'b0, cur_row_reg};
        p_col  = tcce_pkg::COLX_W'(cur_col_reg);
        w_row  = {1'b0, cur_row_reg};
        w_col  = cur_col_reg;
        p_wr   = 1'b0;
        p_char = tcce_pkg::CH_SPACE;
        if (in_data.char_code == tcce_pkg::CH_BACKSPACE)
        begin
            if (cur_col_reg != '0)
            begin
                p_col = tcce_pkg::COLX_W'(cur_col_reg) - 1'b1;
            end
            else if (cur_row_reg != '0)
            begin
                p_row = {1'b0, cur_row_reg} - 1'b1;
                p_col = tcce_pkg::COLX_W'(tcce_pkg::COLUMNS - 1);
            end
            // blank lands on the new cursor cell
            w_row = p_row;
            w_col = tcce_pkg::COL_W'(p_col);
            p_wr  = 1'b1;
        end
        else if (in_data.char_code == tcce_pkg::CH_NEWLINE)
        begin
            p_col = '0;
            p_row = {1'b0, cur_row_reg} + 1'b1;
        end
        else if (in_data.char_code == tcce_pkg::CH_TAB)
        begin
            p_col = tcce_pkg::COLX_W'(cur_col_reg) + tcce_pkg::COLX_W'(tcce_pkg::TAB_STEP);
            if (p_col >= tcce_pkg::COLX_W'(tcce_pkg::COLUMNS))
            begin
                p_col = '0;
                p_row = {1'b0, cur_row_reg} + 1'b1;
            end
        end
        else
        begin
            p_wr   = 1'b1;
            p_char = in_data.char_code;
            p_col  = tcce_pkg::COLX_W'(cur_col_reg) + 1'b1;
            if (p_col >= tcce_pkg::COLX_W'(tcce_pkg::COLUMNS))
            begin
                p_col = '0;
                p_row = {1'b0, cur_row_reg} + 1'b1;
            end
        end
        p_scroll    = (p_row >= (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS));
        p_row_final = p_scroll ? tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)
                               : p_row[tcce_pkg::ROW_W-1:0];
        p_res.cell_value = '0;
        p_res.cursor_row = 5'(p_row_final);
        p_res.cursor_col = 7'(p_col);
        p_res.did_scroll = p_scroll;
    end

    // sequencer: next state, ram accesses, result handling
    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        clr_cnt_next = clr_cnt_reg;
        scr_cnt_next = scr_cnt_reg;
        scr_row_next = scr_row_reg;
        rd_hit_next  = rd_hit_reg;
        pend_next    = pend_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = tcce_pkg::phys_addr(top_reg, w_row, w_col);
        ram_wr_data  = {attr_reg, p_char};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = tcce_pkg::phys_addr(top_reg,
                                           (tcce_pkg::ROW_W+1)'(in_data.read_row),
                                           tcce_pkg::COL_W'(in_data.read_col));
        load_out     = 1'b0;
        load_val     = pend_reg;

        unique case (state_reg)
            tcce_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = tcce_pkg::BLANK_CELL;
                if (clr_cnt_reg == tcce_pkg::ADDR_W'(tcce_pkg::DEPTH - 1))
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            tcce_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == tcce_pkg::OP_READ)
                    begin
                        ram_rd_en   = rd_in_range;
                        rd_hit_next = rd_in_range;
                        state_next  = tcce_pkg::ST_READ;
                    end
                    else
                    begin
                        ram_wr_en    = p_wr;
                        cur_row_next = p_row_final;
                        cur_col_next = tcce_pkg::COL_W'(p_col);
                        if (p_scroll)
                        begin
                            // old top row becomes the new bottom line
                            top_next = (top_reg == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1))
                                     ? '0 : top_reg + 1'b1;
                            scr_row_next = top_reg;
                            scr_cnt_next = '0;
                            pend_next    = p_res;
                            state_next   = tcce_pkg::ST_SCROLL;
                        end
                        else if (out_free)
                        begin
                            load_out = 1'b1;
                            load_val = p_res;
                        end
                        else
                        begin
                            pend_next  = p_res;
                            state_next = tcce_pkg::ST_DONE;
                        end
                    end
                end
            end
            tcce_pkg::ST_READ:
            begin
                pend_next.cell_value = rd_hit_reg ? ram_rd_data : '0;
                pend_next.cursor_row = 5'(cur_row_reg);
                pend_next.cursor_col = 7'(cur_col_reg);
                pend_next.did_scroll = 1'b0;
                state_next           = tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_SCROLL:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = tcce_pkg::row_addr(scr_row_reg, scr_cnt_reg);
                ram_wr_data = {attr_reg, tcce_pkg::CH_SPACE};
                if (scr_cnt_reg == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1))
                begin
                    state_next = tcce_pkg::ST_DONE;
                end
                else
                begin
                    scr_cnt_next = scr_cnt_reg + 1'b1;
                end
            end
            tcce_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcce_pkg::ST_CLEAR;
            end
        endcase

        out_next = out_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_next       = load_val;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcce_pkg::ST_CLEAR;
            attr_reg      <= tcce_pkg::ATTR_RESET;
            top_reg       <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            clr_cnt_reg   <= '0;
            scr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            clr_cnt_reg   <= clr_cnt_next;
            scr_cnt_reg   <= scr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scr_row_reg <= scr_row_next;
        rd_hit_reg  <= rd_hit_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    a_cur_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg < tcce_pkg::ROWS)
        else $error("cursor row beyond last row");

    a_cur_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg < tcce_pkg::COLUMNS)
        else $error("cursor column beyond last column");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg < tcce_pkg::ROWS)
        else $error("ring offset out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result overwrites one still waiting");

    a_scroll_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.op == tcce_pkg::OP_PUT && p_scroll)
        |=> (state_reg == tcce_pkg::ST_SCROLL && cur_row_reg == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)))
        else $error("scrolling put did not start line clear");

endmodule
